// ===== sv/iruart_pkg.sv =====
// ----------------------------------------------------------------------------
// iruart_pkg
// Shared types and constants of the infrared UART transmitter (8E1 framing).
// ----------------------------------------------------------------------------
package iruart_pkg;

    localparam int unsigned REG_W       = 16;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 4;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned FRAME_BITS  = 11;
    localparam int unsigned BIT_IDX_W   = 4;

    typedef logic [REG_W-1:0]      t_reg;
    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [BIT_IDX_W-1:0]  t_bit_idx;

    // register index (word address paddr[3:2])
    typedef enum logic [1:0] {
        REG_BIT_PERIOD  = 2'd0,
        REG_CARRIER_TOP = 2'd1,
        REG_CARRIER_CMP = 2'd2,
        REG_UNUSED      = 2'd3
    } t_reg_idx;

    localparam t_reg BIT_PERIOD_RST  = 16'd40000;
    localparam t_reg CARRIER_TOP_RST = 16'd1249;
    localparam t_reg CARRIER_CMP_RST = 16'd624;

    localparam t_frame   FRAME_IDLE = '1;
    localparam t_bit_idx LAST_BIT   = t_bit_idx'(FRAME_BITS - 1);

    // start bit 0, data LSB first, even parity, stop bit 1
    function automatic t_frame build_frame(input logic [DATA_W-1:0] data);
        build_frame = {1'b1, ^data, data, 1'b0};
    endfunction

endpackage

// ===== sv/ir_uart_transmitter_even_parity.sv =====
// ----------------------------------------------------------------------------
// ir_uart_transmitter_even_parity
// Infrared UART transmitter, 8 data bits, even parity, one stop bit, zero bits
// keyed onto a free-running carrier.
// ----------------------------------------------------------------------------
// Each input word is one transmitter tick carrying an optional start request
// and a byte. The block takes one word per cycle unless a held result stalls it
// and returns one registered result word per input word; the whole tick is
// evaluated in one pass of logic ahead of the result register,
// whose bit-timing path (17-bit increment and compare against the bit period)
// sets the clock. A start while idle loads the frame (start 0, data LSB first,
// even parity, stop 1) and the start bit shows on that same tick; a start
// while busy is dropped with accepted = 0. Each bit lasts bit_period_ticks
// ticks (0 is taken as 1). The carrier counter steps once per tick through
// 0..carrier_top and ir_out is on while the line bit is 0 and the carrier
// count is at or above carrier_compare. Registers sit at byte addresses 0, 4
// and 8 of the APB port and should be written only while no frame is in
// flight.
// ----------------------------------------------------------------------------
module ir_uart_transmitter_even_parity (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_start_req,
    input  logic [iruart_pkg::DATA_W-1:0]       i_data_byte,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_ir_out,
    output logic                                o_line_bit,
    output logic                                o_busy_res,
    output logic                                o_accepted,
    // APB configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iruart_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [iruart_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [iruart_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                pready
);

    // configuration registers
    iruart_pkg::t_reg r_bit_period;
    iruart_pkg::t_reg r_carrier_top;
    iruart_pkg::t_reg r_carrier_cmp;

    // transmitter state
    iruart_pkg::t_frame   r_frame_shift, n_frame_shift;
    iruart_pkg::t_bit_idx r_bit_index,   n_bit_index;
    iruart_pkg::t_reg     r_tick_count,  n_tick_count;
    iruart_pkg::t_reg     r_carrier,     n_carrier;
    logic                 r_sending,     n_sending;

    // result register
    logic r_out_valid;
    logic r_ir_out, n_ir_out;
    logic r_line_bit, n_line_bit;
    logic r_busy_res, n_busy_res;
    logic r_accepted, n_accepted;

    logic                 in_fire;
    logic                 cfg_wr;
    iruart_pkg::t_reg_idx cfg_idx;

    // tick evaluation intermediates
    logic                         start_ok;
    iruart_pkg::t_frame           cur_shift;
    iruart_pkg::t_bit_idx         cur_index;
    iruart_pkg::t_reg             cur_tick;
    iruart_pkg::t_reg             period;
    logic [iruart_pkg::REG_W:0]   tick_inc;

    // Output register frees itself when taken, so a new word is taken even
    // while the previous result is leaving.
    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = iruart_pkg::t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;

    always_comb begin
        unique case (cfg_idx)
            iruart_pkg::REG_BIT_PERIOD:  prdata = iruart_pkg::APB_DATA_W'(r_bit_period);
            iruart_pkg::REG_CARRIER_TOP: prdata = iruart_pkg::APB_DATA_W'(r_carrier_top);
            iruart_pkg::REG_CARRIER_CMP: prdata = iruart_pkg::APB_DATA_W'(r_carrier_cmp);
            default:                     prdata = '0;
        endcase
    end

    // One tick: start handling, outputs from the updated frame and the
    // pre-advance carrier count, then carrier and bit timing advance.
    always_comb begin
        start_ok  = i_start_req && !r_sending;
        cur_shift = start_ok ? iruart_pkg::build_frame(i_data_byte) : r_frame_shift;
        cur_index = start_ok ? '0 : r_bit_index;
        cur_tick  = start_ok ? '0 : r_tick_count;
        n_sending = r_sending || start_ok;

        n_line_bit = n_sending ? cur_shift[0] : 1'b1;
        n_ir_out   = !n_line_bit && (r_carrier >= r_carrier_cmp);
        n_busy_res = n_sending;
        n_accepted = start_ok;

        // carrier: wrap at top (a count above top also drops to zero)
        n_carrier = (r_carrier >= r_carrier_top) ? '0 : r_carrier + 1'b1;

        period   = (r_bit_period == '0) ? iruart_pkg::t_reg'(1) : r_bit_period;
        tick_inc = {1'b0, cur_tick} + 1'b1;

        n_frame_shift = cur_shift;
        n_bit_index   = cur_index;
        n_tick_count  = cur_tick;

        if (n_sending) begin
            if (tick_inc >= {1'b0, period}) begin
                n_tick_count = '0;
                if (cur_index == iruart_pkg::LAST_BIT) begin
                    // stop bit has run its full period
                    n_frame_shift = iruart_pkg::FRAME_IDLE;
                    n_bit_index   = '0;
                    n_sending     = 1'b0;
                end else begin
                    n_frame_shift = {1'b1, cur_shift[iruart_pkg::FRAME_BITS-1:1]};
                    n_bit_index   = cur_index + 1'b1;
                end
            end else begin
                n_tick_count = tick_inc[iruart_pkg::REG_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period  <= iruart_pkg::BIT_PERIOD_RST;
            r_carrier_top <= iruart_pkg::CARRIER_TOP_RST;
            r_carrier_cmp <= iruart_pkg::CARRIER_CMP_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                iruart_pkg::REG_BIT_PERIOD:  r_bit_period  <= pwdata[iruart_pkg::REG_W-1:0];
                iruart_pkg::REG_CARRIER_TOP: r_carrier_top <= pwdata[iruart_pkg::REG_W-1:0];
                iruart_pkg::REG_CARRIER_CMP: r_carrier_cmp <= pwdata[iruart_pkg::REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_shift <= iruart_pkg::FRAME_IDLE;
            r_bit_index   <= '0;
            r_tick_count  <= '0;
            r_carrier     <= '0;
            r_sending     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_fire) begin
                r_frame_shift <= n_frame_shift;
                r_bit_index   <= n_bit_index;
                r_tick_count  <= n_tick_count;
                r_carrier     <= n_carrier;
                r_sending     <= n_sending;
                r_out_valid   <= 1'b1;
            end else if (i_ready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ir_out   <= n_ir_out;
            r_line_bit <= n_line_bit;
            r_busy_res <= n_busy_res;
            r_accepted <= n_accepted;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_ir_out   = r_ir_out;
    assign o_line_bit = r_line_bit;
    assign o_busy_res = r_busy_res;
    assign o_accepted = r_accepted;

endmodule

// ===== sv/iruart_chk.sv =====
// ----------------------------------------------------------------------------
// iruart_chk
// Port-level checks for the infrared UART transmitter, bound to the top level.
// ----------------------------------------------------------------------------
module iruart_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic                                o_ir_out,
    input logic                                o_line_bit,
    input logic                                o_busy_res,
    input logic                                o_accepted
);

    // a taken start shows the start bit on the same word
    a_start_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> o_busy_res && !o_line_bit)
        else $error("accepted start without start bit");

    // carrier only keys a zero bit of a frame in flight
    a_ir_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ir_out |-> !o_line_bit && o_busy_res)
        else $error("ir_out outside a zero bit");

    // idle line is high and dark
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_line_bit && !o_ir_out)
        else $error("idle line not marking");

    // a held result must block new input
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("input taken while result stalled");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_line_bit) && $stable(o_accepted))
        else $error("stalled result changed");

endmodule

bind ir_uart_transmitter_even_parity iruart_chk u_iruart_chk (.*);
